// ===== rtl/rcflh_pkg.sv =====
// ----------------------------------------------------------------------------
// rcflh_pkg
// Shared types, constants and helper functions for the random color fader
// with LED history.
// ----------------------------------------------------------------------------
package rcflh_pkg;

	// history store geometry
	localparam int LED_DEPTH = 256;
	localparam int HIST_AW   = $clog2(LED_DEPTH);

	// color and fade widths
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 3;
	localparam int COLOR_W = CH_W * NUM_CH;
	localparam int FADE_W  = 8;
	localparam int SPAN_W  = FADE_W + 1;
	localparam int NUM_W   = 2 * CH_W;
	localparam int FIELD_W = 5;

	// noise shift register
	localparam int                LFSR_W    = 16;
	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hbeef;

	// fade register reset value
	localparam logic [FADE_W-1:0] FADE_STEPS_RST = 8'd63;

	// divider: one quotient bit per step, quotient always fits a channel
	localparam int DIV_STEPS = CH_W;
	localparam int DIV_CW    = $clog2(DIV_STEPS);

	// request codes
	typedef enum logic [1:0] {
		REQ_ENTROPY = 2'd0,
		REQ_FRAME   = 2'd1,
		REQ_READ    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	// request from the sequencer to the blend unit
	typedef struct packed {
		logic                 start;
		logic [SPAN_W-1:0]    span;
		logic [FADE_W-1:0]    pos;
		logic [COLOR_W-1:0]   from_color;
		logic [COLOR_W-1:0]   to_color;
	} blend_req_t;

	// one LFSR step, taps at bits 0, 2, 3 and 5, feedback into the top bit
	function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] v);
		logic fb;
		fb = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {fb, v[LFSR_W-1:1]};
	endfunction

	// (f*8)^2 >> 8 reduces to f^2 >> 2
	function automatic logic [CH_W-1:0] gamma_field(input logic [FIELD_W-1:0] f);
		logic [2*FIELD_W-1:0] sq;
		sq = f * f;
		return sq[2*FIELD_W-1:2];
	endfunction

endpackage

// ===== rtl/rcflh_ram.sv =====
// ----------------------------------------------------------------------------
// rcflh_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that appears in the cycle after the read address.
// ----------------------------------------------------------------------------
module rcflh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/rcflh_blend.sv =====
// ----------------------------------------------------------------------------
// rcflh_blend
// Linear interpolation of three color channels: a registered weighted-product
// step, then a restoring divide by the span, one quotient bit per cycle
// in three parallel lanes.
// ----------------------------------------------------------------------------
module rcflh_blend (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcflh_pkg::blend_req_t         req,
	output logic                          done,
	output logic [rcflh_pkg::COLOR_W-1:0] color
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_MUL  = 3'b010,
		B_DIV  = 3'b100
	} blend_state_t;

	blend_state_t state_q;
	logic [rcflh_pkg::DIV_CW-1:0] cnt_q;
	logic                         done_q;

	// per-lane partial remainder and dividend/quotient shift register
	logic [rcflh_pkg::SPAN_W-1:0] rem_q  [rcflh_pkg::NUM_CH];
	logic [rcflh_pkg::CH_W-1:0]   quo_q  [rcflh_pkg::NUM_CH];
	logic [rcflh_pkg::SPAN_W-1:0] rem_mul [rcflh_pkg::NUM_CH];
	logic [rcflh_pkg::CH_W-1:0]   quo_mul [rcflh_pkg::NUM_CH];
	logic [rcflh_pkg::SPAN_W-1:0] rem_div [rcflh_pkg::NUM_CH];
	logic [rcflh_pkg::CH_W-1:0]   quo_div [rcflh_pkg::NUM_CH];

	// weighted sum per lane: from*(span-pos) + to*pos
	always_comb begin
		logic [rcflh_pkg::SPAN_W-1:0] wfrom;
		logic [rcflh_pkg::CH_W-1:0]   a;
		logic [rcflh_pkg::CH_W-1:0]   b;
		logic [rcflh_pkg::NUM_W:0]    num;
		wfrom = req.span - rcflh_pkg::SPAN_W'(req.pos);
		for (int l = 0; l < rcflh_pkg::NUM_CH; l++) begin
			a = req.from_color[(rcflh_pkg::NUM_CH-1-l)*rcflh_pkg::CH_W +: rcflh_pkg::CH_W];
			b = req.to_color[(rcflh_pkg::NUM_CH-1-l)*rcflh_pkg::CH_W +: rcflh_pkg::CH_W];
			num = (rcflh_pkg::NUM_W+1)'(a) * (rcflh_pkg::NUM_W+1)'(wfrom)
			    + (rcflh_pkg::NUM_W+1)'(b) * (rcflh_pkg::NUM_W+1)'(req.pos);
			// sum stays below 256*span, so its upper byte is already below span
			rem_mul[l] = rcflh_pkg::SPAN_W'(num[rcflh_pkg::NUM_W-1:rcflh_pkg::CH_W]);
			quo_mul[l] = num[rcflh_pkg::CH_W-1:0];
		end
	end

	// one restoring divide step per lane
	always_comb begin
		logic [rcflh_pkg::SPAN_W:0] trial;
		logic                       ge;
		for (int l = 0; l < rcflh_pkg::NUM_CH; l++) begin
			trial = {rem_q[l], quo_q[l][rcflh_pkg::CH_W-1]};
			ge    = trial >= {1'b0, req.span};
			rem_div[l] = ge ? rcflh_pkg::SPAN_W'(trial - {1'b0, req.span})
			                : trial[rcflh_pkg::SPAN_W-1:0];
			quo_div[l] = {quo_q[l][rcflh_pkg::CH_W-2:0], ge};
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (req.start) begin
						state_q <= B_MUL;
					end
				end
				B_MUL: begin
					cnt_q   <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == rcflh_pkg::DIV_CW'(rcflh_pkg::DIV_STEPS - 1)) begin
						state_q <= B_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// lane datapath
	always_ff @(posedge clk) begin
		for (int l = 0; l < rcflh_pkg::NUM_CH; l++) begin
			if (state_q == B_MUL) begin
				rem_q[l] <= rem_mul[l];
				quo_q[l] <= quo_mul[l];
			end else if (state_q == B_DIV) begin
				rem_q[l] <= rem_div[l];
				quo_q[l] <= quo_div[l];
			end
		end
	end

	assign done  = done_q;
	assign color = {quo_q[0], quo_q[1], quo_q[2]};

endmodule

// ===== rtl/random_color_fade_led_history.sv =====
// ----------------------------------------------------------------------------
// random_color_fade_led_history
// Random color fader: an LFSR stirred by noise bits picks target colors,
// frames blend from the previous target and push the head color into a
// 256-entry history RAM that reads back by age.
//
//   channel  | signals                                   | direction
//   ---------+-------------------------------------------+----------
//   input    | in_valid, in_stall, req_type,             | in
//            | entropy_bit, led_position                 |
//   output   | out_valid, out_stall, red, green, blue    | out
//   config   | cfg_we, cfg_wdata (fade_steps)            | in
//
// An entropy tick only steps the LFSR and leaves the input free. A frame
// runs through the blend unit: a product step and an 8-step restoring
// divide. A read waits in S_RDWAIT for the registered RAM read data.
// One word is in flight at a time; a finished word waits in the output
// register while the next word is accepted. Reset clears all history
// entries at once through per-entry valid bits, so no clearing pass.
// ----------------------------------------------------------------------------
module random_color_fade_led_history (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   req_type,
	input  logic                         entropy_bit,
	input  logic [7:0]                   led_position,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [rcflh_pkg::CH_W-1:0]   red,
	output logic [rcflh_pkg::CH_W-1:0]   green,
	output logic [rcflh_pkg::CH_W-1:0]   blue,
	// configuration
	input  logic                         cfg_we,
	input  logic [rcflh_pkg::FADE_W-1:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_BLEND  = 4'b0010,
		S_RDWAIT = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [rcflh_pkg::FADE_W-1:0]   fade_steps_q;
	logic [rcflh_pkg::LFSR_W-1:0]   lfsr_q;
	logic [rcflh_pkg::COLOR_W-1:0]  from_q;
	logic [rcflh_pkg::COLOR_W-1:0]  to_q;
	logic [rcflh_pkg::FADE_W-1:0]   pos_q;
	logic [rcflh_pkg::HIST_AW-1:0]  head_q;
	logic [rcflh_pkg::LED_DEPTH-1:0] hist_vld_q;
	logic                           start_q;
	logic                           is_frame_q;
	logic                           rd_vld_s1;
	logic [rcflh_pkg::COLOR_W-1:0]  res_q;
	logic                           out_valid_q;
	logic [rcflh_pkg::COLOR_W-1:0]  out_color_q;

	logic                           in_acc;
	logic                           out_free;
	logic                           hist_we;
	logic [rcflh_pkg::HIST_AW-1:0]  hist_waddr;
	logic [rcflh_pkg::HIST_AW-1:0]  hist_raddr;
	logic [rcflh_pkg::COLOR_W-1:0]  hist_rdata;
	logic                           rd_oor;
	logic [rcflh_pkg::LFSR_W-1:0]   lfsr_mix;
	logic [rcflh_pkg::COLOR_W-1:0]  new_target;
	rcflh_pkg::blend_req_t          blend_req;
	logic                           blend_done;
	logic [rcflh_pkg::COLOR_W-1:0]  blend_color;

	// handshake
	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// noise mix and gamma-corrected new target
	assign lfsr_mix   = lfsr_q ^ {entropy_bit, {(rcflh_pkg::LFSR_W-1){1'b0}}};
	assign new_target = {rcflh_pkg::gamma_field(lfsr_q[4:0]),
	                     rcflh_pkg::gamma_field(lfsr_q[9:5]),
	                     rcflh_pkg::gamma_field(lfsr_q[14:10])};

	// history read address by age, write slot after the head
	assign hist_raddr = head_q - led_position[rcflh_pkg::HIST_AW-1:0];
	assign rd_oor     = 32'(led_position) >= 32'(rcflh_pkg::LED_DEPTH);
	assign hist_waddr = head_q + 1'b1;
	assign hist_we    = (state_q == S_DONE) && out_free && is_frame_q;

	// blend request
	assign blend_req.start      = start_q;
	assign blend_req.span       = {1'b0, fade_steps_q} + 1'b1;
	assign blend_req.pos        = pos_q;
	assign blend_req.from_color = from_q;
	assign blend_req.to_color   = to_q;

	rcflh_blend u_blend (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (blend_req),
		.done   (blend_done),
		.color  (blend_color)
	);

	rcflh_ram #(
		.WIDTH (rcflh_pkg::COLOR_W),
		.DEPTH (rcflh_pkg::LED_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (res_q),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	// control and fade state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fade_steps_q <= rcflh_pkg::FADE_STEPS_RST;
			lfsr_q       <= rcflh_pkg::LFSR_SEED;
			from_q       <= '0;
			to_q         <= '0;
			pos_q        <= '0;
			head_q       <= '0;
			hist_vld_q   <= '0;
			start_q      <= 1'b0;
			is_frame_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// blend start pulse on an accepted frame
			start_q <= in_acc && (req_type == rcflh_pkg::REQ_FRAME);
			if (cfg_we) begin
				fade_steps_q <= cfg_wdata;
			end
			// output word valid: set on a finished word, cleared once taken
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						case (req_type)
							rcflh_pkg::REQ_ENTROPY: begin
								lfsr_q <= rcflh_pkg::lfsr_advance(lfsr_mix);
							end
							rcflh_pkg::REQ_FRAME: begin
								// new fade once the position reaches the step count
								if (pos_q >= fade_steps_q) begin
									pos_q  <= '0;
									from_q <= to_q;
									to_q   <= new_target;
								end else begin
									pos_q <= pos_q + 1'b1;
								end
								is_frame_q <= 1'b1;
								state_q    <= S_BLEND;
							end
							rcflh_pkg::REQ_READ: begin
								rd_vld_s1  <= hist_vld_q[hist_raddr] && !rd_oor;
								is_frame_q <= 1'b0;
								state_q    <= S_RDWAIT;
							end
							default: begin
							end
						endcase
					end
				end
				S_BLEND: begin
					if (blend_done) begin
						state_q <= S_DONE;
					end
				end
				S_RDWAIT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (is_frame_q) begin
							head_q                 <= hist_waddr;
							hist_vld_q[hist_waddr] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result and output payload
	always_ff @(posedge clk) begin
		if (state_q == S_BLEND && blend_done) begin
			res_q <= blend_color;
		end else if (state_q == S_RDWAIT) begin
			res_q <= rd_vld_s1 ? hist_rdata : '0;
		end
		if (state_q == S_DONE && out_free) begin
			out_color_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = out_color_q[2*rcflh_pkg::CH_W +: rcflh_pkg::CH_W];
	assign green     = out_color_q[rcflh_pkg::CH_W +: rcflh_pkg::CH_W];
	assign blue      = out_color_q[0 +: rcflh_pkg::CH_W];

endmodule

// ===== rtl/rcflh_checker.sv =====
// ----------------------------------------------------------------------------
// rcflh_checker
// Port-level checks on the color fader: handshake behavior and the
// sequencing of words through the block.
// ----------------------------------------------------------------------------
module rcflh_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic [1:0]                   req_type,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [rcflh_pkg::CH_W-1:0]   red,
	input logic [rcflh_pkg::CH_W-1:0]   green,
	input logic [rcflh_pkg::CH_W-1:0]   blue,
	input logic                         cfg_we,
	input logic [rcflh_pkg::FADE_W-1:0] cfg_wdata
);

	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
		&& $stable(blue))
		else $error("stalled output word changed");

	// frames and reads keep the input stalled while they work
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (req_type == rcflh_pkg::REQ_FRAME || req_type == rcflh_pkg::REQ_READ)
		|=> in_stall)
		else $error("input not stalled after frame or read");

	// an entropy tick produces no word
	a_entropy_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type == rcflh_pkg::REQ_ENTROPY |=> !$rose(out_valid))
		else $error("word produced by entropy tick");

	// a new word only follows a busy period
	a_word_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("word appeared without work in progress");

	// configuration data is never unknown when written
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_wdata))
		else $error("unknown configuration data");

endmodule

bind random_color_fade_led_history rcflh_checker u_rcflh_checker (.*);

// ===== tb/tb_random_color_fade_led_history.sv =====
// ----------------------------------------------------------------------------
// tb_random_color_fade_led_history
// Self-checking bench for the random color fader with LED history. A
// behavioral fader tracks the noise LFSR, the fade and the 256-entry color
// history on every accepted request and queues the color each frame or read
// must return. Returned words are compared field by field. Runs directed
// corner requests, an output hold-off that backs the block up, a drain pause
// and random traffic under several fade_steps settings with random idling.
// ----------------------------------------------------------------------------
module tb_random_color_fade_led_history;

	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES   = 400;

	typedef struct packed {
		logic [rcflh_pkg::CH_W-1:0] r;
		logic [rcflh_pkg::CH_W-1:0] g;
		logic [rcflh_pkg::CH_W-1:0] b;
	} rgb_t;

	logic                         clk;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [1:0]                   req_type;
	logic                         entropy_bit;
	logic [7:0]                   led_position;
	logic                         out_valid;
	logic                         out_stall;
	logic [rcflh_pkg::CH_W-1:0]   red;
	logic [rcflh_pkg::CH_W-1:0]   green;
	logic [rcflh_pkg::CH_W-1:0]   blue;
	logic                         cfg_we;
	logic [rcflh_pkg::FADE_W-1:0] cfg_wdata;

	// fader state as the bench sees it
	logic [rcflh_pkg::LFSR_W-1:0]  lfsr_s       = rcflh_pkg::LFSR_SEED;
	logic [rcflh_pkg::COLOR_W-1:0] from_rgb     = '0;
	logic [rcflh_pkg::COLOR_W-1:0] to_rgb       = '0;
	logic [rcflh_pkg::FADE_W-1:0]  fade_pos     = '0;
	logic [rcflh_pkg::FADE_W-1:0]  fade_steps_s = rcflh_pkg::FADE_STEPS_RST;
	logic [rcflh_pkg::COLOR_W-1:0] history [0:rcflh_pkg::LED_DEPTH-1] = '{default: '0};
	logic [7:0]                    newest       = '0;

	rgb_t pending_colors [$];

	int err_count      = 0;
	int words_sent     = 0;
	int colors_checked = 0;
	int settings_done  = 0;
	int tx_max_gap     = 15;
	int rx_max_wait    = 15;
	int hold_left      = 0;

	random_color_fade_led_history DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.entropy_bit  (entropy_bit),
		.led_position (led_position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("timeout: block stopped moving words");
		$display("== FAIL ==");
		$finish;
	end

	// gamma curve of one 5-bit field: (f*8)^2 / 256
	function automatic logic [rcflh_pkg::CH_W-1:0] gamma_of(
		logic [rcflh_pkg::FIELD_W-1:0] f);
		int unsigned x;
		x = f * 8;
		return rcflh_pkg::CH_W'((x * x) >> 8);
	endfunction

	// linear mix of one channel at the current fade position
	function automatic logic [rcflh_pkg::CH_W-1:0] blend_ch(logic [rcflh_pkg::CH_W-1:0] a,
		logic [rcflh_pkg::CH_W-1:0] b);
		int unsigned span;
		int unsigned v;
		span = fade_steps_s + 1;
		v = a * (span - fade_pos) + b * fade_pos;
		return rcflh_pkg::CH_W'(v / span);
	endfunction

	// update fader state for one accepted request, queue the color it returns
	task automatic advance_fader(rcflh_pkg::req_t req, logic ebit, logic [7:0] age);
		logic                          fb;
		logic [rcflh_pkg::COLOR_W-1:0] head;
		logic [7:0]                    slot;
		case (req)
			rcflh_pkg::REQ_ENTROPY: begin
				lfsr_s = lfsr_s ^ {ebit, 15'd0};
				fb = lfsr_s[0] ^ lfsr_s[2] ^ lfsr_s[3] ^ lfsr_s[5];
				lfsr_s = {fb, lfsr_s[rcflh_pkg::LFSR_W-1:1]};
			end
			rcflh_pkg::REQ_FRAME: begin
				// new target once the fade has run out, also when steps were lowered
				if (fade_pos >= fade_steps_s) begin
					fade_pos = '0;
					from_rgb = to_rgb;
					to_rgb = {gamma_of(lfsr_s[4:0]), gamma_of(lfsr_s[9:5]),
						gamma_of(lfsr_s[14:10])};
				end else begin
					fade_pos = fade_pos + 1'b1;
				end
				head = {blend_ch(from_rgb[23:16], to_rgb[23:16]),
					blend_ch(from_rgb[15:8], to_rgb[15:8]),
					blend_ch(from_rgb[7:0], to_rgb[7:0])};
				newest = newest + 1'b1;
				history[newest] = head;
				pending_colors.push_back(head);
			end
			rcflh_pkg::REQ_READ: begin
				slot = newest - age;
				pending_colors.push_back(history[slot]);
			end
			default: begin
				// unused code: no effect
			end
		endcase
	endtask

	task automatic flag_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	// send one word: random gap, then hold it until accepted
	task automatic send_word(rcflh_pkg::req_t req, logic ebit, logic [7:0] age);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= req;
		entropy_bit  <= ebit;
		led_position <= age;
		do @(posedge clk); while (in_stall);
		advance_fader(req, ebit, age);
		if (req != rcflh_pkg::REQ_NONE)
			words_sent++;
	endtask

	// stop sending and wait until every queued color is back and the block is quiet
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_colors.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_fade_steps(logic [rcflh_pkg::FADE_W-1:0] v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		fade_steps_s = v;
		settings_done++;
	endtask

	// random mix of requests, count excludes the unused code
	task automatic random_words(int count);
		int              n;
		int              pick;
		rcflh_pkg::req_t req;
		logic [7:0]      age;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				req = rcflh_pkg::REQ_ENTROPY;
			else if (pick < 75)
				req = rcflh_pkg::REQ_FRAME;
			else if (pick < 95)
				req = rcflh_pkg::REQ_READ;
			else
				req = rcflh_pkg::REQ_NONE;
			age = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0)
				age = $urandom_range(0, 1) ? 8'd255 : 8'd0;
			send_word(req, 1'($urandom_range(0, 1)), age);
			if (req != rcflh_pkg::REQ_NONE)
				n++;
		end
	endtask

	// untouched history reads back as zero
	task automatic test_history_after_reset();
		send_word(rcflh_pkg::REQ_READ, 1'b0, 8'd0);
		send_word(rcflh_pkg::REQ_READ, 1'b1, 8'd1);
		send_word(rcflh_pkg::REQ_READ, 1'b0, 8'd128);
		send_word(rcflh_pkg::REQ_READ, 1'b1, 8'd255);
	endtask

	// each request code with field extremes
	task automatic test_each_request();
		send_word(rcflh_pkg::REQ_ENTROPY, 1'b0, 8'd255);
		send_word(rcflh_pkg::REQ_ENTROPY, 1'b1, 8'd0);
		send_word(rcflh_pkg::REQ_NONE, 1'b1, 8'd255);
		send_word(rcflh_pkg::REQ_FRAME, 1'b0, 8'd0);
		send_word(rcflh_pkg::REQ_FRAME, 1'b1, 8'd255);
		send_word(rcflh_pkg::REQ_FRAME, 1'b0, 8'd17);
		send_word(rcflh_pkg::REQ_READ, 1'b0, 8'd0);
		send_word(rcflh_pkg::REQ_READ, 1'b1, 8'd2);
		send_word(rcflh_pkg::REQ_READ, 1'b0, 8'd255);
	endtask

	// zero steps: every frame jumps and shows the previous target
	task automatic test_fade_jump();
		set_fade_steps(8'd0);
		send_word(rcflh_pkg::REQ_FRAME, 1'b1, 8'd255);
		send_word(rcflh_pkg::REQ_ENTROPY, 1'b1, 8'd0);
		send_word(rcflh_pkg::REQ_FRAME, 1'b0, 8'd0);
		send_word(rcflh_pkg::REQ_READ, 1'b0, 8'd1);
	endtask

	// lowering steps below the running position starts a new fade
	task automatic test_position_above_steps();
		int i;
		set_fade_steps(8'd8);
		for (i = 0; i < 6; i++)
			send_word(rcflh_pkg::REQ_FRAME, 1'b0, 8'd0);
		set_fade_steps(8'd2);
		send_word(rcflh_pkg::REQ_FRAME, 1'b0, 8'd0);
		send_word(rcflh_pkg::REQ_FRAME, 1'b1, 8'd0);
		send_word(rcflh_pkg::REQ_READ, 1'b0, 8'd0);
	endtask

	// receiver holds off while the sender keeps pushing, block must back up
	task automatic test_output_holdoff();
		int i;
		tx_max_gap = 0;
		hold_left  = HOLD_CYCLES;
		for (i = 0; i < 30; i++)
			send_word((i % 4 == 3) ? rcflh_pkg::REQ_READ : rcflh_pkg::REQ_FRAME, 1'b0,
				i[7:0]);
		drain_results();
		tx_max_gap = 15;
	endtask

	// sender pauses until every color has come back, then resumes
	task automatic test_pause_for_drain();
		random_words(20);
		drain_results();
		random_words(20);
	endtask

	// random traffic over several fade_steps settings and idling profiles
	task automatic test_random_settings();
		logic [rcflh_pkg::FADE_W-1:0] steps [0:5];
		int ph;
		steps = '{8'd255, 8'd1, 8'd0, 8'd3, 8'($urandom_range(0, 255)),
			rcflh_pkg::FADE_STEPS_RST};
		for (ph = 0; ph < 6; ph++) begin
			set_fade_steps(steps[ph]);
			case (ph % 3)
				0: begin tx_max_gap = 15; rx_max_wait = 15; end
				1: begin tx_max_gap = 0;  rx_max_wait = 0;  end
				default: begin tx_max_gap = 0; rx_max_wait = 15; end
			endcase
			random_words(170);
		end
		tx_max_gap  = 15;
		rx_max_wait = 15;
	endtask

	// result side: check each accepted word, then draw the next stall
	initial begin : color_checker
		int   wait_left;
		rgb_t want;
		wait_left = 0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_colors.size() == 0) begin
					flag_mismatch("unexpected word, red", red, 0);
				end else begin
					want = pending_colors.pop_front();
					if (red !== want.r)
						flag_mismatch("red", red, want.r);
					if (green !== want.g)
						flag_mismatch("green", green, want.g);
					if (blue !== want.b)
						flag_mismatch("blue", blue, want.b);
				end
				colors_checked++;
				wait_left = $urandom_range(0, rx_max_wait);
			end
			// long hold-off first, then the per-word stall
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (wait_left > 0) begin
				wait_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// test sequence
	initial begin
		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		req_type     <= rcflh_pkg::REQ_NONE;
		entropy_bit  <= 1'b0;
		led_position <= '0;
		cfg_we       <= 1'b0;
		cfg_wdata    <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_history_after_reset();
		test_each_request();
		test_fade_jump();
		test_position_above_steps();
		test_output_holdoff();
		test_pause_for_drain();
		test_random_settings();

		drain_results();
		$display("covered %0d requests, %0d color words checked, %0d fade_steps writes",
			words_sent, colors_checked, settings_done);
		$display("incl. reset history, fade jump, steps lowered mid-fade, output hold-off");
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== random_color_fade_led_history.f =====
rtl/rcflh_pkg.sv
rtl/rcflh_ram.sv
rtl/rcflh_blend.sv
rtl/random_color_fade_led_history.sv
rtl/rcflh_checker.sv
tb/tb_random_color_fade_led_history.sv
